@@ design/hfp_pkg.sv @@
// Shared types, character codes and helpers for the header field parser.
// No dependencies; imported by every module of the block.
package hfp_pkg;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_NAME  = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_VEOL  = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_t;

  // Result kinds as carried on out_tuser[2:0]
  typedef enum logic [2:0] {
    K_NAME_BYTE  = 3'd0,
    K_NAME_END   = 3'd1,
    K_VALUE_BYTE = 3'd2,
    K_FIELD_END  = 3'd3,
    K_HDR_END    = 3'd4,
    K_ERROR      = 3'd5
  } kind_t;

  // Error codes carried with K_ERROR
  localparam logic ERR_UNTERMINATED = 1'b0;
  localparam logic ERR_NO_VALUE     = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Default depth of the result queue
  localparam int HFP_FIFO_DEPTH = 4;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       err;
    logic       last;
  } result_t;

  // Results produced by one accepted transaction (count is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CHAR_LF) || (c == CHAR_CR);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) ? (c | CASE_BIT) : c;
  endfunction

endpackage

@@ design/hfp_step.sv @@
// Per-byte parser state machine: holds phase and part flags, and forms the
// up to two results of each accepted transaction. Depends on hfp_pkg.
module hfp_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept_i,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output hfp_pkg::push_t push_o
);
  import hfp_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   part_consumed_r, part_consumed_nxt;
  logic   emitted_nonspace_r, emitted_nonspace_nxt;
  logic   space_pending_r, space_pending_nxt;

  // Work out results and next state for the byte on the input
  always_comb begin : step_logic
    logic [7:0] c;
    logic       eot;
    logic       run_name;
    logic       do_char;
    logic [7:0] char_v;
    kind_t      char_kind;
    logic [1:0] cnt;
    result_t    res [2];

    c         = in_tdata;
    eot       = in_tlast;
    run_name  = 1'b0;
    do_char   = 1'b0;
    char_v    = c;
    char_kind = K_VALUE_BYTE;
    cnt       = 2'd0;
    res[0]    = '0;
    res[1]    = '0;

    phase_nxt            = phase_r;
    part_consumed_nxt    = part_consumed_r;
    emitted_nonspace_nxt = emitted_nonspace_r;
    space_pending_nxt    = space_pending_r;

    unique case (phase_r)
      PH_NAME: begin
        if (eot) begin
          res[0] = '{data: 8'h00, kind: (part_consumed_r ? K_ERROR : K_HDR_END),
                     err: ERR_UNTERMINATED, last: 1'b0};
          cnt = 2'd1;
          part_consumed_nxt    = 1'b0;
          emitted_nonspace_nxt = 1'b0;
          space_pending_nxt    = 1'b0;
        end else begin
          run_name = 1'b1;
        end
      end
      PH_VALUE: begin
        if (eot) begin
          res[0] = '{data: 8'h00, kind: K_ERROR, err: ERR_UNTERMINATED, last: 1'b0};
          cnt = 2'd1;
          phase_nxt            = PH_NAME;
          part_consumed_nxt    = 1'b0;
          emitted_nonspace_nxt = 1'b0;
          space_pending_nxt    = 1'b0;
        end else if (is_eol(c)) begin
          phase_nxt = PH_VEOL;
        end else if (is_ws(c)) begin
          part_consumed_nxt = 1'b1;
          if (emitted_nonspace_r) space_pending_nxt = 1'b1;
        end else begin
          do_char   = 1'b1;
          char_kind = K_VALUE_BYTE;
        end
      end
      PH_VEOL: begin
        if (!eot && ((c == CHAR_SPACE) || (c == CHAR_TAB))) begin
          // folded line: line end and blank count as whitespace
          part_consumed_nxt = 1'b1;
          if (emitted_nonspace_r) space_pending_nxt = 1'b1;
          phase_nxt = PH_VALUE;
        end else if (!part_consumed_r) begin
          res[0] = '{data: 8'h00, kind: K_ERROR, err: ERR_NO_VALUE, last: 1'b0};
          cnt = 2'd1;
          phase_nxt            = eot ? PH_NAME : PH_SKIP;
          emitted_nonspace_nxt = eot ? 1'b0 : emitted_nonspace_r;
          space_pending_nxt    = eot ? 1'b0 : space_pending_r;
        end else begin
          res[0] = '{data: 8'h00, kind: K_FIELD_END, err: 1'b0, last: 1'b0};
          cnt = 2'd1;
          phase_nxt            = PH_NAME;
          part_consumed_nxt    = 1'b0;
          emitted_nonspace_nxt = 1'b0;
          space_pending_nxt    = 1'b0;
          if (eot) begin
            res[1] = '{data: 8'h00, kind: K_HDR_END, err: 1'b0, last: 1'b0};
            cnt = 2'd2;
          end else begin
            run_name = 1'b1;
          end
        end
      end
      default: begin
        // skipping: only the terminator matters
        if (eot) begin
          phase_nxt            = PH_NAME;
          part_consumed_nxt    = 1'b0;
          emitted_nonspace_nxt = 1'b0;
          space_pending_nxt    = 1'b0;
        end
      end
    endcase

    // Handle a byte as part of a name
    if (run_name) begin
      if ((c == CHAR_COLON) || is_eol(c)) begin
        if (!part_consumed_nxt) begin
          res[cnt[0]] = '{data: 8'h00, kind: K_HDR_END, err: 1'b0, last: 1'b0};
          cnt = cnt + 2'd1;
          phase_nxt = PH_SKIP;
        end else begin
          res[cnt[0]] = '{data: 8'h00, kind: K_NAME_END, err: 1'b0, last: 1'b0};
          cnt = cnt + 2'd1;
          phase_nxt            = PH_VALUE;
          part_consumed_nxt    = 1'b0;
          emitted_nonspace_nxt = 1'b0;
          space_pending_nxt    = 1'b0;
        end
      end else if (is_ws(c)) begin
        part_consumed_nxt = 1'b1;
        if (emitted_nonspace_nxt) space_pending_nxt = 1'b1;
      end else begin
        do_char   = 1'b1;
        char_v    = to_lower(c);
        char_kind = K_NAME_BYTE;
      end
    end

    // Emit a held space, then the byte itself
    if (do_char) begin
      part_consumed_nxt = 1'b1;
      if (space_pending_nxt) begin
        res[cnt[0]] = '{data: CHAR_SPACE, kind: char_kind, err: 1'b0, last: 1'b0};
        cnt = cnt + 2'd1;
      end
      res[cnt[0]] = '{data: char_v, kind: char_kind, err: 1'b0, last: 1'b0};
      cnt = cnt + 2'd1;
      emitted_nonspace_nxt = 1'b1;
      space_pending_nxt    = 1'b0;
    end

    // Mark the final result of this transaction
    if (cnt != 2'd0) res[~cnt[0]].last = 1'b1;

    push_o.count = cnt;
    push_o.r0    = res[0];
    push_o.r1    = res[1];
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_NAME;
      part_consumed_r    <= 1'b0;
      emitted_nonspace_r <= 1'b0;
      space_pending_r    <= 1'b0;
    end else if (accept_i) begin
      phase_r            <= phase_nxt;
      part_consumed_r    <= part_consumed_nxt;
      emitted_nonspace_r <= emitted_nonspace_nxt;
      space_pending_r    <= space_pending_nxt;
    end
  end

endmodule

@@ design/hfp_out_fifo.sv @@
// Result queue: takes up to two results per cycle, delivers one per cycle
// while out_ready_i is high. Depends on hfp_pkg.
module hfp_out_fifo #(
  parameter int DEPTH = hfp_pkg::HFP_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_en_i,
  input  hfp_pkg::push_t   push_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hfp_pkg::result_t out_res_o
);
  import hfp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  result_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    n_push;
  logic          pop;

  function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  // Room for a full two-result transaction
  assign space_o     = (count_r <= CW'(DEPTH - 2));
  assign out_valid_o = (count_r != '0);
  assign out_res_o   = mem_r[rd_ptr_r];

  assign n_push  = push_en_i ? push_i.count : 2'd0;
  assign pop     = out_valid_o && out_ready_i;
  assign wr_ptr1 = inc_ptr(wr_ptr_r);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (n_push == 2'd1) wr_ptr_nxt = wr_ptr1;
    else if (n_push == 2'd2) wr_ptr_nxt = inc_ptr(wr_ptr1);
    rd_ptr_nxt = pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming results
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_ptr_r] <= push_i.r0;
    if (n_push == 2'd2) mem_r[wr_ptr1] <= push_i.r1;
  end

endmodule

@@ design/header_field_parser_unit.sv @@
// Top level of the header field parser: byte parser feeding a result queue.
// Depends on hfp_pkg, hfp_step and hfp_out_fifo.
//
//   channel | direction | tdata         | tuser                     | tlast
//   in_     | slave     | [7:0] byte    | -                         | end of text
//   out_    | master    | [7:0] byte    | [2:0] kind, [3] err code  | last of item
//
// Each input byte is parsed in the cycle it is accepted; its zero, one or two
// results land in the result queue and leave one per cycle while out_tready
// is high. One input per cycle is sustained while each byte gives at most one
// result and out_tready is high. in_tready drops when the queue lacks room for
// two results. Synchronous active-low reset empties the queue and returns the
// parser to name start.
module header_field_parser_unit #(
  parameter int FIFO_DEPTH = hfp_pkg::HFP_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [3:0] out_tuser,  // [2:0] kind, [3] err_code
  output logic       out_tlast
);
  import hfp_pkg::*;

  logic    in_accept;
  push_t   push;
  result_t head;

  assign in_accept = in_tvalid && in_tready;

  hfp_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (in_accept),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .push_o   (push)
  );

  hfp_out_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_en_i   (in_accept),
    .push_i      (push),
    .space_o     (in_tready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (head)
  );

  // Drive the result channel from the queue head
  assign out_tdata = head.data;
  assign out_tuser = {head.err, head.kind};
  assign out_tlast = head.last;

  // A stalled input means results are waiting
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result queue");

  // A transaction that yields results makes the output valid next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (push.count != 2'd0)) |=> out_tvalid)
    else $error("results of a transaction not visible");

  // Events carry a zero byte
  a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (head.kind != K_NAME_BYTE) && (head.kind != K_VALUE_BYTE))
      |-> (out_tdata == 8'h00))
    else $error("event result with non-zero byte");

  // Error code only with error kind; at most two results per transaction
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (head.kind == K_ERROR))
    else $error("error code set on non-error result");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (push.count != 2'd3))
    else $error("more than two results for one transaction");

endmodule
